FILE: src/yuvb_pkg.sv
package yuvb_pkg;

	localparam int PPR_W         = 11;
	localparam int DEF_MAX_PAIRS = 1024;
	localparam int CH_W          = 8;
	localparam int SUM_W         = 20;

	localparam logic [PPR_W-1:0] PPR_RESET = 11'd1;

	localparam logic signed [SUM_W-1:0] K_Y   = 20'sd298;
	localparam logic signed [SUM_W-1:0] K_BU  = 20'sd516;
	localparam logic signed [SUM_W-1:0] K_GU  = 20'sd100;
	localparam logic signed [SUM_W-1:0] K_GV  = 20'sd208;
	localparam logic signed [SUM_W-1:0] K_RV  = 20'sd409;
	localparam logic signed [SUM_W-1:0] K_RND = 20'sd128;
	localparam logic signed [8:0]       Y_OFS = 9'sd16;
	localparam logic signed [8:0]       C_OFS = 9'sd128;

	typedef struct packed {
		logic            frame_start;
		logic [CH_W-1:0] luma_first;
		logic [CH_W-1:0] luma_second;
		logic [CH_W-1:0] chroma_blue;
		logic [CH_W-1:0] chroma_red;
	} in_beat_t;

	typedef struct packed {
		logic [CH_W-1:0] blue_first;
		logic [CH_W-1:0] green_first;
		logic [CH_W-1:0] red_first;
		logic [CH_W-1:0] blue_second;
		logic [CH_W-1:0] green_second;
		logic [CH_W-1:0] red_second;
		logic            row_end;
	} out_beat_t;

	function automatic logic [CH_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
		logic [CH_W-1:0] r;
		if (s[SUM_W-1]) begin
			r = '0;
		end else if (|s[SUM_W-2:16]) begin
			r = '1;
		end else begin
			r = s[15:8];
		end
		return r;
	endfunction

endpackage

FILE: src/yuvb_if.sv
interface yuvb_in_if import yuvb_pkg::*; ();
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface yuvb_out_if import yuvb_pkg::*; ();
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface yuvb_cfg_if import yuvb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PPR_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/yuv420_to_bgra_converter_unit.sv
// Converts a raster stream of 4:2:0 video into pairs of BGR pixels.
// The pix_in channel takes one beat per luma pair: two luma samples and
// one chroma pair, with frame_start on the first pair of a frame. The
// pix_out channel returns one beat per input beat with both converted
// pixels and row_end on the last pair of each row. The cfg channel writes
// the number of pairs in a row; it is always ready. The user must write it
// only while the block is idle; the block does not enforce this.
// Chroma from even rows is kept in a line store of MAX_PAIRS entries and
// read back for the same column on the following odd row.
// An accepted input beat passes registered stages s1, s2 and s3 to pix_out.
// Throughput is one beat per cycle unless the receiver stalls; the line store
// takes one access per cycle, a write on even rows and a read on odd rows.
// When the receiver stalls, the whole pipeline holds and pix_in.ready
// drops until the output beat is taken.
// Reset clears the pipeline, the column and row state and sets the row
// length to one pair. The line store is not cleared.
module yuv420_to_bgra_converter_unit import yuvb_pkg::*; #(
	parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
	input  logic        clk,
	input  logic        arst_n,
	yuvb_cfg_if.sink    cfg,
	yuvb_in_if.sink     pix_in,
	yuvb_out_if.source  pix_out
);

	localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int LW = $clog2(MAX_PAIRS + 1);
	localparam int CW = (LW > PPR_W) ? LW : PPR_W;

	logic [PPR_W-1:0] ppr_q;
	logic [AW-1:0]    col_q;
	logic             odd_q;

	logic             en;
	logic             acc;
	logic [AW-1:0]    col_eff;
	logic             odd_eff;
	logic [CW-1:0]    col_ext;
	logic [CW-1:0]    ppr_ext;
	logic [CW-1:0]    len;
	logic             last_w;

	logic [15:0]      line_mem [MAX_PAIRS];
	logic [15:0]      rd_q;

	logic             v_s1;
	logic             odd_s1;
	logic             end_s1;
	logic [CH_W-1:0]  y1_s1;
	logic [CH_W-1:0]  y2_s1;
	logic [CH_W-1:0]  cb_s1;
	logic [CH_W-1:0]  cr_s1;

	logic [CH_W-1:0]  cb_sel;
	logic [CH_W-1:0]  cr_sel;
	logic signed [8:0] ua;
	logic signed [8:0] va;
	logic signed [8:0] y1a;
	logic signed [8:0] y2a;

	logic             v_s2;
	logic             end_s2;
	logic signed [SUM_W-1:0] c1_s2;
	logic signed [SUM_W-1:0] c2_s2;
	logic signed [SUM_W-1:0] bu_s2;
	logic signed [SUM_W-1:0] gu_s2;
	logic signed [SUM_W-1:0] gv_s2;
	logic signed [SUM_W-1:0] rv_s2;

	logic signed [SUM_W-1:0] b1;
	logic signed [SUM_W-1:0] g1;
	logic signed [SUM_W-1:0] r1;
	logic signed [SUM_W-1:0] b2;
	logic signed [SUM_W-1:0] g2;
	logic signed [SUM_W-1:0] r2;

	logic             v_s3;
	out_beat_t        res_s3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q <= PPR_RESET;
		end else if (cfg.valid) begin
			ppr_q <= cfg.data;
		end
	end

	assign en           = !v_s3 || pix_out.ready;
	assign pix_in.ready = en;
	assign acc          = pix_in.valid && en;

	assign col_eff = pix_in.data.frame_start ? '0 : col_q;
	assign odd_eff = pix_in.data.frame_start ? 1'b0 : odd_q;
	assign col_ext = CW'(col_eff);
	assign ppr_ext = CW'(ppr_q);

	always_comb begin
		if (ppr_ext == '0) begin
			len = CW'(1);
		end else if (ppr_ext > CW'(MAX_PAIRS)) begin
			len = CW'(MAX_PAIRS);
		end else begin
			len = ppr_ext;
		end
	end

	assign last_w = col_ext >= (len - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
		end else if (acc) begin
			if (last_w) begin
				col_q <= '0;
				odd_q <= !odd_eff;
			end else begin
				col_q <= col_eff + AW'(1);
				odd_q <= odd_eff;
			end
		end
	end

	// An odd row reads a column at least one beat after the even row wrote it,
	// so the registered read always sees the stored pair.
	always_ff @(posedge clk) begin
		if (acc && !odd_eff) begin
			line_mem[col_eff] <= {pix_in.data.chroma_red, pix_in.data.chroma_blue};
		end
		if (acc && odd_eff) begin
			rd_q <= line_mem[col_eff];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			odd_s1 <= odd_eff;
			end_s1 <= last_w;
			y1_s1  <= pix_in.data.luma_first;
			y2_s1  <= pix_in.data.luma_second;
			cb_s1  <= pix_in.data.chroma_blue;
			cr_s1  <= pix_in.data.chroma_red;
		end
	end

	assign cb_sel = odd_s1 ? rd_q[7:0] : cb_s1;
	assign cr_sel = odd_s1 ? rd_q[15:8] : cr_s1;
	assign ua  = $signed({1'b0, cb_sel}) - C_OFS;
	assign va  = $signed({1'b0, cr_sel}) - C_OFS;
	assign y1a = $signed({1'b0, y1_s1}) - Y_OFS;
	assign y2a = $signed({1'b0, y2_s1}) - Y_OFS;

	always_ff @(posedge clk) begin
		if (en) begin
			end_s2 <= end_s1;
			c1_s2  <= {{(SUM_W-9){y1a[8]}}, y1a} * K_Y;
			c2_s2  <= {{(SUM_W-9){y2a[8]}}, y2a} * K_Y;
			bu_s2  <= {{(SUM_W-9){ua[8]}}, ua} * K_BU;
			gu_s2  <= {{(SUM_W-9){ua[8]}}, ua} * K_GU;
			gv_s2  <= {{(SUM_W-9){va[8]}}, va} * K_GV;
			rv_s2  <= {{(SUM_W-9){va[8]}}, va} * K_RV;
		end
	end

	assign b1 = c1_s2 + bu_s2 + K_RND;
	assign g1 = c1_s2 - gu_s2 - gv_s2 + K_RND;
	assign r1 = c1_s2 + rv_s2 + K_RND;
	assign b2 = c2_s2 + bu_s2 + K_RND;
	assign g2 = c2_s2 - gu_s2 - gv_s2 + K_RND;
	assign r2 = c2_s2 + rv_s2 + K_RND;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.blue_first   <= clamp_chan(b1);
			res_s3.green_first  <= clamp_chan(g1);
			res_s3.red_first    <= clamp_chan(r1);
			res_s3.blue_second  <= clamp_chan(b2);
			res_s3.green_second <= clamp_chan(g2);
			res_s3.red_second   <= clamp_chan(r2);
			res_s3.row_end      <= end_s2;
		end
	end

	assign pix_out.valid = v_s3;
	assign pix_out.data  = res_s3;

	a_frame_start_col: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pix_in.data.frame_start && !last_w |=> col_q == AW'(1) && !odd_q)
		else $error("frame start did not restart the column count");

	a_row_end_col: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_w |=> col_q == '0)
		else $error("column did not wrap at the end of a row");

	a_row_end_parity: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_w && !pix_in.data.frame_start |=> odd_q != $past(odd_q))
		else $error("row parity did not toggle at the end of a row");

endmodule
